/* sv/swrm_pkg.sv */
// ----------------------------------------------------------------------------
// swrm_pkg: shared constants and types for the stream rate meter
// Field widths, register indexes, command codes, scale factors and the
// state type of the execution engine.
// ----------------------------------------------------------------------------
package swrm_pkg;

  localparam int FRAME_W     = 32;
  localparam int TOTAL_W     = 32;
  localparam int COUNT_OUT_W = 7;
  localparam int FPS_W       = 32;
  localparam int MBPS_W      = 40;
  localparam int MAX_ENT_W   = 7;
  localparam int SPAN_W      = 40;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 40;
  localparam int QUOT_W      = 64;
  localparam int MIN_KEEP    = 2;

  // 100 * 1e9 for fps, 100 * 8 * 1e9 / 1e6 for Mbps
  localparam int FPS_SCALE_W  = 37;
  localparam int MBPS_SCALE_W = 20;
  localparam logic [FPS_SCALE_W-1:0]  FPS_SCALE  = 37'd100000000000;
  localparam logic [MBPS_SCALE_W-1:0] MBPS_SCALE = 20'd800000;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_ENTRIES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SPAN = 1'b1;

  localparam logic [MAX_ENT_W-1:0] MAX_ENT_RESET = 7'd50;
  localparam logic [SPAN_W-1:0]    SPAN_RESET    = 40'd5000000000;

  localparam logic FUNC_FRAME = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DROP_RD,
    ST_DROP_EX,
    ST_PUSH,
    ST_EV_RD,
    ST_EV_CHK,
    ST_MUL,
    ST_FPS_GO,
    ST_FPS_WAIT,
    ST_MBPS_GO,
    ST_MBPS_WAIT,
    ST_OUT
  } back_state_e;

endpackage

/* sv/swrm_if.sv */
// ----------------------------------------------------------------------------
// swrm_if: channel interfaces of the stream rate meter
// Input item channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface swrm_in_if #(
  parameter int TimeBits = 48
);
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic [swrm_pkg::FRAME_W-1:0] frame_bytes;
  logic [TimeBits-1:0]          timestamp_ns;

  modport source(output valid, func, frame_bytes, timestamp_ns, input ready);
  modport sink(input valid, func, frame_bytes, timestamp_ns, output ready);
endinterface

interface swrm_out_if;
  logic                             valid;
  logic                             ready;
  logic [swrm_pkg::TOTAL_W-1:0]     total_frames;
  logic [swrm_pkg::COUNT_OUT_W-1:0] window_count;
  logic                             rate_valid;
  logic [swrm_pkg::FPS_W-1:0]       fps_centi;
  logic [swrm_pkg::MBPS_W-1:0]      mbps_centi;

  modport source(output valid, total_frames, window_count, rate_valid, fps_centi,
                 mbps_centi, input ready);
  modport sink(input valid, total_frames, window_count, rate_valid, fps_centi,
               mbps_centi, output ready);
endinterface

interface swrm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [swrm_pkg::CFG_IDX_W-1:0]  index;
  logic [swrm_pkg::CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* sv/swrm_ram.sv */
// ----------------------------------------------------------------------------
// swrm_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module swrm_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

/* sv/swrm_front.sv */
// ----------------------------------------------------------------------------
// swrm_front: input acceptance and command queue
// Takes items, classifies them as frame or clear and holds them in a
// two-entry queue until the execution engine takes them.
// ----------------------------------------------------------------------------
module swrm_front #(
  parameter int TimeBits = 48
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  swrm_in_if.sink                      in_i,
  output logic                         cmd_valid_o,
  output logic                         cmd_clear_o,
  output logic [swrm_pkg::FRAME_W-1:0] cmd_bytes_o,
  output logic [TimeBits-1:0]          cmd_ts_o,
  input  logic                         cmd_ready_i
);
  import swrm_pkg::*;

  logic                clear_q [2];
  logic [FRAME_W-1:0]  bytes_q [2];
  logic [TimeBits-1:0] ts_q    [2];
  logic                wr_ptr_q, wr_ptr_d;
  logic                rd_ptr_q, rd_ptr_d;
  logic [1:0]          fill_q, fill_d;
  logic                push, pop;

  assign in_i.ready  = (fill_q != 2'd2);
  assign push        = in_i.valid && in_i.ready;
  assign cmd_valid_o = (fill_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_clear_o = clear_q[rd_ptr_q];
  assign cmd_bytes_o = bytes_q[rd_ptr_q];
  assign cmd_ts_o    = ts_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      clear_q[wr_ptr_q] <= (in_i.func == FUNC_CLEAR);
      bytes_q[wr_ptr_q] <= in_i.frame_bytes;
      ts_q[wr_ptr_q]    <= in_i.timestamp_ns;
    end
  end
endmodule

/* sv/swrm_div.sv */
// ----------------------------------------------------------------------------
// swrm_div: radix-2 restoring divider
// Divides a 64-bit numerator by a nonzero denominator, one quotient bit
// per cycle; done pulses when the quotient is ready.
// ----------------------------------------------------------------------------
module swrm_div #(
  parameter int DenW = 48
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [swrm_pkg::QUOT_W-1:0] num_i,
  input  logic [DenW-1:0]             den_i,
  output logic                        done_o,
  output logic [swrm_pkg::QUOT_W-1:0] quot_o
);
  import swrm_pkg::*;

  localparam int CntW = $clog2(QUOT_W + 1);

  logic [QUOT_W-1:0] num_q, num_d;
  logic [QUOT_W-1:0] quot_q, quot_d;
  logic [DenW-1:0]   rem_q, rem_d;
  logic [DenW-1:0]   den_q, den_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              run_q, run_d;
  logic              done_q, done_d;
  logic [DenW:0]     rem_sh;
  logic              ge;

  always_comb begin
    rem_sh = {rem_q, num_q[QUOT_W-1]};
    ge     = (rem_sh >= {1'b0, den_q});
    num_d  = num_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      quot_d = '0;
      cnt_d  = CntW'(QUOT_W);
      run_d  = 1'b1;
    end else if (run_q) begin
      rem_d  = ge ? DenW'(rem_sh - {1'b0, den_q}) : rem_sh[DenW-1:0];
      quot_d = {quot_q[QUOT_W-2:0], ge};
      num_d  = {num_q[QUOT_W-2:0], 1'b0};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
endmodule

/* sv/swrm_back.sv */
// ----------------------------------------------------------------------------
// swrm_back: execution engine of the stream rate meter
// Updates the entry ring, evicts old entries, computes both rates with a
// shared serial divider and holds the result until it is taken.
// ----------------------------------------------------------------------------
module swrm_back #(
  parameter int RingDepth = 64,
  parameter int TimeBits  = 48
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cmd_valid_i,
  input  logic                           cmd_clear_i,
  input  logic [swrm_pkg::FRAME_W-1:0]   cmd_bytes_i,
  input  logic [TimeBits-1:0]            cmd_ts_i,
  output logic                           cmd_ready_o,
  input  logic [swrm_pkg::MAX_ENT_W-1:0] max_entries_i,
  input  logic [swrm_pkg::SPAN_W-1:0]    window_span_i,
  swrm_out_if.source                     out_o
);
  import swrm_pkg::*;

  localparam int PtrW  = $clog2(RingDepth);
  localparam int CntW  = $clog2(RingDepth + 1);
  localparam int ByteW = FRAME_W + PtrW;
  localparam int CmpW  = (CntW > MAX_ENT_W) ? CntW : MAX_ENT_W;
  localparam int FpsMulW  = CntW + FPS_SCALE_W;
  localparam int MbpsMulW = ByteW + MBPS_SCALE_W;

  back_state_e state_q, state_d;

  logic [PtrW-1:0]     oldest_q, oldest_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [ByteW-1:0]    bytes_q, bytes_d;
  logic [TOTAL_W-1:0]  total_q, total_d;
  logic [FRAME_W-1:0]  fbytes_q, fbytes_d;
  logic [TimeBits-1:0] ts_q, ts_d;
  logic [TimeBits-1:0] span_q, span_d;
  logic [QUOT_W-1:0]   fps_prod_q, fps_prod_d;
  logic [QUOT_W-1:0]   mbps_prod_q, mbps_prod_d;
  logic                rate_q, rate_d;
  logic [FPS_W-1:0]    fps_q, fps_d;
  logic [MBPS_W-1:0]   mbps_q, mbps_d;

  logic                out_valid_q, out_valid_d;
  logic [TOTAL_W-1:0]  out_total_q, out_total_d;
  logic [CntW-1:0]     out_count_q, out_count_d;
  logic                out_rate_q, out_rate_d;
  logic [FPS_W-1:0]    out_fps_q, out_fps_d;
  logic [MBPS_W-1:0]   out_mbps_q, out_mbps_d;

  logic [CmpW-1:0]     me_ext, cap_ext;
  logic [CntW-1:0]     cap;
  logic [TimeBits-1:0] span_now;
  logic [CntW-1:0]     cnt_m1;
  logic [FpsMulW-1:0]  fps_mul;
  logic [MbpsMulW-1:0] mbps_mul;
  logic                evict;
  logic                out_load;

  logic                ram_we;
  logic [PtrW-1:0]     ram_waddr, size_raddr;
  logic [FRAME_W-1:0]  size_rd;
  logic [TimeBits-1:0] time_rd;

  logic                div_start, div_done;
  logic [QUOT_W-1:0]   div_num, div_quot;

  function automatic logic [PtrW-1:0] ring_add(input logic [PtrW-1:0] a,
                                               input logic [PtrW-1:0] b);
    logic [PtrW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (PtrW+1)'(RingDepth)) begin
      s = s - (PtrW+1)'(RingDepth);
    end
    return s[PtrW-1:0];
  endfunction

  // clamp capacity to the usable range of the ring
  always_comb begin
    me_ext = CmpW'(max_entries_i);
    if (me_ext < CmpW'(MIN_KEEP + 1)) begin
      cap_ext = CmpW'(MIN_KEEP + 1);
    end else if (me_ext > CmpW'(RingDepth)) begin
      cap_ext = CmpW'(RingDepth);
    end else begin
      cap_ext = me_ext;
    end
    cap = CntW'(cap_ext);
  end

  assign span_now   = ts_q - time_rd;
  assign evict      = (count_q > CntW'(MIN_KEEP)) &&
                      (64'(span_now) > 64'(window_span_i));
  assign ram_we     = (state_q == ST_PUSH);
  assign ram_waddr  = ring_add(oldest_q, PtrW'(count_q));
  assign size_raddr = ring_add(oldest_q, PtrW'(1));
  assign out_load   = !out_valid_q || out_o.ready;
  assign cnt_m1     = count_q - 1'b1;
  assign fps_mul    = FpsMulW'(cnt_m1) * FpsMulW'(FPS_SCALE);
  assign mbps_mul   = MbpsMulW'(bytes_q) * MbpsMulW'(MBPS_SCALE);

  assign div_start = (state_q == ST_FPS_GO) || (state_q == ST_MBPS_GO);
  assign div_num   = ((state_q == ST_FPS_GO) ? fps_prod_q : mbps_prod_q) +
                     QUOT_W'(span_q >> 1);

  assign cmd_ready_o = (state_q == ST_IDLE);

  swrm_ram #(.Width(FRAME_W), .Depth(RingDepth)) u_size_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (fbytes_q),
    .raddr_i (size_raddr),
    .rdata_o (size_rd)
  );

  swrm_ram #(.Width(TimeBits), .Depth(RingDepth)) u_time_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ts_q),
    .raddr_i (oldest_q),
    .rdata_o (time_rd)
  );

  swrm_div #(.DenW(TimeBits)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (span_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_clear_i) begin
            state_d = ST_OUT;
          end else if (count_q >= cap) begin
            state_d = ST_DROP_RD;
          end else begin
            state_d = ST_PUSH;
          end
        end
      end
      ST_DROP_RD:  state_d = ST_DROP_EX;
      ST_DROP_EX:  state_d = ST_PUSH;
      ST_PUSH:     state_d = (count_q != '0) ? ST_EV_RD : ST_OUT;
      ST_EV_RD:    state_d = ST_EV_CHK;
      ST_EV_CHK: begin
        if (evict) begin
          state_d = ST_EV_RD;
        end else if (span_now == '0) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_MUL:       state_d = ST_FPS_GO;
      ST_FPS_GO:    state_d = ST_FPS_WAIT;
      ST_FPS_WAIT:  state_d = div_done ? ST_MBPS_GO : ST_FPS_WAIT;
      ST_MBPS_GO:   state_d = ST_MBPS_WAIT;
      ST_MBPS_WAIT: state_d = div_done ? ST_OUT : ST_MBPS_WAIT;
      ST_OUT:       state_d = out_load ? ST_IDLE : ST_OUT;
      default:      state_d = ST_IDLE;
    endcase
  end

  // datapath updates
  always_comb begin
    oldest_d    = oldest_q;
    count_d     = count_q;
    bytes_d     = bytes_q;
    total_d     = total_q;
    fbytes_d    = fbytes_q;
    ts_d        = ts_q;
    span_d      = span_q;
    fps_prod_d  = fps_prod_q;
    mbps_prod_d = mbps_prod_q;
    rate_d      = rate_q;
    fps_d       = fps_q;
    mbps_d      = mbps_q;
    out_valid_d = out_valid_q;
    out_total_d = out_total_q;
    out_count_d = out_count_q;
    out_rate_d  = out_rate_q;
    out_fps_d   = out_fps_q;
    out_mbps_d  = out_mbps_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          fbytes_d = cmd_bytes_i;
          ts_d     = cmd_ts_i;
          rate_d   = 1'b0;
          fps_d    = '0;
          mbps_d   = '0;
          if (cmd_clear_i) begin
            oldest_d = '0;
            count_d  = '0;
            bytes_d  = '0;
            total_d  = '0;
          end
        end
      end
      ST_DROP_EX: begin
        bytes_d  = bytes_q - ByteW'(size_rd);
        oldest_d = size_raddr;
        count_d  = count_q - 1'b1;
      end
      ST_PUSH: begin
        if (count_q != '0) begin
          bytes_d = bytes_q + ByteW'(fbytes_q);
        end
        count_d = count_q + 1'b1;
        total_d = total_q + 1'b1;
      end
      ST_EV_CHK: begin
        span_d = span_now;
        if (evict) begin
          bytes_d  = bytes_q - ByteW'(size_rd);
          oldest_d = size_raddr;
          count_d  = count_q - 1'b1;
        end
      end
      ST_MUL: begin
        fps_prod_d  = QUOT_W'(fps_mul);
        mbps_prod_d = QUOT_W'(mbps_mul);
      end
      ST_FPS_WAIT: begin
        if (div_done) begin
          fps_d = (|div_quot[QUOT_W-1:FPS_W]) ? '1 : div_quot[FPS_W-1:0];
        end
      end
      ST_MBPS_WAIT: begin
        if (div_done) begin
          mbps_d = (|div_quot[QUOT_W-1:MBPS_W]) ? '1 : div_quot[MBPS_W-1:0];
          rate_d = 1'b1;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          out_total_d = total_q;
          out_count_d = count_q;
          out_rate_d  = rate_q;
          out_fps_d   = fps_q;
          out_mbps_d  = mbps_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      oldest_q    <= '0;
      count_q     <= '0;
      bytes_q     <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      oldest_q    <= oldest_d;
      count_q     <= count_d;
      bytes_q     <= bytes_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fbytes_q    <= fbytes_d;
    ts_q        <= ts_d;
    span_q      <= span_d;
    fps_prod_q  <= fps_prod_d;
    mbps_prod_q <= mbps_prod_d;
    rate_q      <= rate_d;
    fps_q       <= fps_d;
    mbps_q      <= mbps_d;
    out_total_q <= out_total_d;
    out_count_q <= out_count_d;
    out_rate_q  <= out_rate_d;
    out_fps_q   <= out_fps_d;
    out_mbps_q  <= out_mbps_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.total_frames = out_total_q;
  assign out_o.window_count = COUNT_OUT_W'(out_count_q);
  assign out_o.rate_valid   = out_rate_q;
  assign out_o.fps_centi    = out_fps_q;
  assign out_o.mbps_centi   = out_mbps_q;
endmodule

/* sv/sliding_window_stream_rate_meter_unit.sv */
// ----------------------------------------------------------------------------
// sliding_window_stream_rate_meter_unit: frame rate and throughput meter
// Sliding window of recent frames giving frame count, fps and Mbps.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  : frame events (func 0, frame_bytes, timestamp_ns) or clear (func 1).
//   out_o : one result per item: total_frames, window_count, rate_valid,
//           fps_centi and mbps_centi (hundredths, rounded, saturating).
//   cfg_i : register writes, index 0 = max_entries, 1 = window_span_ns;
//           always ready, write only while no item is in flight.
// Execution: a clear goes straight to the output; a frame drops the oldest
//   entry if the ring is full, is pushed, evicts old entries one at a time,
//   then runs both rate divisions on the shared one-bit-per-cycle divider.
//   One item is executed at a time; a two-entry queue lets the source run
//   ahead.
// Reset: the window and frame count are empty, max_entries 50 and
//   window_span_ns 5e9. The entry ring needs no clearing pass.
// Stall: a result waits in the output register while ready is low; the
//   engine takes the next queued item meanwhile and waits only to deliver.
// ----------------------------------------------------------------------------
module sliding_window_stream_rate_meter_unit #(
  parameter int RING_DEPTH = 64,
  parameter int TIME_BITS  = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  swrm_in_if.sink     in_i,
  swrm_out_if.source  out_o,
  swrm_cfg_if.sink    cfg_i
);
  import swrm_pkg::*;

  logic [MAX_ENT_W-1:0] max_entries_q, max_entries_d;
  logic [SPAN_W-1:0]    window_span_q, window_span_d;

  logic                 cmd_valid, cmd_clear, cmd_ready;
  logic [FRAME_W-1:0]   cmd_bytes;
  logic [TIME_BITS-1:0] cmd_ts;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    max_entries_d = max_entries_q;
    window_span_d = window_span_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_MAX_ENTRIES: max_entries_d = cfg_i.data[MAX_ENT_W-1:0];
        REG_WINDOW_SPAN: window_span_d = cfg_i.data[SPAN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_entries_q <= MAX_ENT_RESET;
      window_span_q <= SPAN_RESET;
    end else begin
      max_entries_q <= max_entries_d;
      window_span_q <= window_span_d;
    end
  end

  swrm_front #(.TimeBits(TIME_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_valid_o (cmd_valid),
    .cmd_clear_o (cmd_clear),
    .cmd_bytes_o (cmd_bytes),
    .cmd_ts_o    (cmd_ts),
    .cmd_ready_i (cmd_ready)
  );

  swrm_back #(.RingDepth(RING_DEPTH), .TimeBits(TIME_BITS)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_clear_i   (cmd_clear),
    .cmd_bytes_i   (cmd_bytes),
    .cmd_ts_i      (cmd_ts),
    .cmd_ready_o   (cmd_ready),
    .max_entries_i (max_entries_q),
    .window_span_i (window_span_q),
    .out_o         (out_o)
  );
endmodule

/* sim/swrm_tb_if.sv */
// ----------------------------------------------------------------------------
// swrm_tb_if: testbench clock source
// Free-running clock for the stream rate meter testbench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
interface swrm_tb_clk_if;
  logic clk;
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end
endinterface

/* sim/sliding_window_stream_rate_meter_unit_tb.sv */
// ----------------------------------------------------------------------------
// sliding_window_stream_rate_meter_unit_tb: stream rate meter testbench
// Drives frame and clear items with random gaps, predicts count, occupancy
// and rounded fps/Mbps in a local window model, and checks every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module sliding_window_stream_rate_meter_unit_tb;
  import swrm_pkg::*;

  localparam int  DEPTH     = 64;
  localparam int  EXP_DEPTH = 1024;
  localparam int  LIMIT     = 2000000;
  localparam logic [47:0] TMASK = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [31:0] total;
    logic [6:0]  count;
    logic        rv;
    logic [31:0] fps;
    logic [39:0] mbps;
  } rate_res_t;

  swrm_tb_clk_if ck();
  logic clk_i;
  logic rst_ni;
  assign clk_i = ck.clk;

  swrm_in_if  #(.TimeBits(48)) in_ch();
  swrm_out_if out_ch();
  swrm_cfg_if cfg_ch();

  sliding_window_stream_rate_meter_unit u_top (
    .clk_i (clk_i), .rst_ni(rst_ni), .in_i(in_ch), .out_o(out_ch), .cfg_i(cfg_ch)
  );

  // window model
  logic [31:0] m_size [DEPTH];
  logic [47:0] m_time [DEPTH];
  int unsigned m_oldest, m_count, m_cap_reg;
  logic [63:0] m_bytes, m_span_lim;
  logic [31:0] m_total;

  // expected results, written at input acceptance, read at output acceptance
  rate_res_t   exp_mem [EXP_DEPTH];
  int unsigned exp_wr, exp_rd;
  int          errors, cycles;
  bit          stall_en;
  logic [47:0] now_ts;

  function automatic int unsigned pending_cnt();
    return exp_wr - exp_rd;
  endfunction

  function automatic int unsigned rpos(int unsigned off);
    return (m_oldest + off) % DEPTH;
  endfunction

  function automatic logic [63:0] cur_span();
    return (m_time[rpos(m_count - 1)] - m_time[m_oldest]) & TMASK;
  endfunction

  function automatic void evict_one();
    if (m_count == 0) return;
    if (m_count >= 2) m_bytes -= m_size[rpos(1)];
    else m_bytes = 0;
    m_oldest = rpos(1);
    m_count--;
  endfunction

  function automatic logic [63:0] rdiv(logic [63:0] n, logic [63:0] d, logic [63:0] mx);
    logic [63:0] q;
    q = (n + d / 2) / d;
    return q > mx ? mx : q;
  endfunction

  function automatic rate_res_t predict_rates(logic fn, logic [31:0] b, logic [47:0] ts);
    rate_res_t r;
    int unsigned cap, slot;
    logic [63:0] sp;
    cap = m_cap_reg;
    if (cap < 3) cap = 3;
    if (cap > DEPTH) cap = DEPTH;
    if (fn == FUNC_CLEAR) begin
      m_oldest = 0; m_count = 0; m_bytes = 0; m_total = 0;
    end else begin
      if (m_count >= cap) evict_one();
      slot = rpos(m_count);
      m_size[slot] = b;
      m_time[slot] = ts;
      if (m_count >= 1) m_bytes += 64'(b);
      m_count++;
      m_total++;
      while (m_count > MIN_KEEP && cur_span() > m_span_lim) evict_one();
    end
    r = '0;
    r.total = m_total;
    r.count = m_count[6:0];
    if (m_count >= 2) begin
      sp = cur_span();
      if (sp != 0) begin
        r.rv   = 1'b1;
        r.fps  = 32'(rdiv(64'(m_count - 1) * 64'd100000000000, sp, 64'hFFFF_FFFF));
        r.mbps = 40'(rdiv(m_bytes * 64'd800000, sp, 64'hFF_FFFF_FFFF));
      end
    end
    return r;
  endfunction

  initial begin
    in_ch.valid = 1'b0; in_ch.func = 1'b0; in_ch.frame_bytes = '0; in_ch.timestamp_ns = '0;
    cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result checker and receiver stalls
  int stall_left;
  always @(posedge clk_i) begin
    rate_res_t got, exp_r;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        got.total = out_ch.total_frames; got.count = out_ch.window_count;
        got.rv = out_ch.rate_valid; got.fps = out_ch.fps_centi; got.mbps = out_ch.mbps_centi;
        if (pending_cnt() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %p", got);
        end else begin
          exp_r = exp_mem[exp_rd % EXP_DEPTH];
          exp_rd++;
          if (got !== exp_r) begin
            errors++;
            if (errors <= 10) $display("mismatch exp %p got %p", exp_r, got);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ch.ready <= 1'b0;
      end else if (stall_en && $urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(1, 7) - 1;
        out_ch.ready <= 1'b0;
      end else out_ch.ready <= 1'b1;
    end
  end

  task automatic send_item(logic fn, logic [31:0] b, logic [47:0] ts);
    int gap;
    if (stall_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1; in_ch.func <= fn; in_ch.frame_bytes <= b; in_ch.timestamp_ns <= ts;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    exp_mem[exp_wr % EXP_DEPTH] = predict_rates(fn, b, ts);
    exp_wr++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_cnt() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [39:0] val);
    cfg_ch.valid <= 1'b1; cfg_ch.index <= idx; cfg_ch.data <= val;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_MAX_ENTRIES) m_cap_reg = val[6:0];
    else m_span_lim = 64'(val);
    @(posedge clk_i);
  endtask

  task automatic frame_at(logic [31:0] b, logic [63:0] step);
    now_ts = (now_ts + step[47:0]) & TMASK;
    send_item(FUNC_FRAME, b, now_ts);
  endtask

  task automatic test_directed();
    send_item(FUNC_FRAME, 32'hFFFF_FFFF, 48'h0);
    send_item(FUNC_FRAME, 32'h0, 48'h0);                 // zero span
    send_item(FUNC_FRAME, 32'hFFFF_FFFF, 48'h1);          // saturating rates
    send_item(FUNC_FRAME, 32'h1234, 48'hFFFF_FFFF_FFFF);  // large span
    send_item(FUNC_CLEAR, 32'hFFFF_FFFF, TMASK);
    now_ts = 48'hFFFF_FFFF_F000;                          // wrap forward
    repeat (6) frame_at(32'd1500, 64'd1000);
    send_item(FUNC_FRAME, 32'd10, now_ts - 48'd5);        // time goes back
    send_item(FUNC_CLEAR, 32'd0, 48'd0);
    now_ts = 0;
    repeat (5) frame_at(32'd1000, 64'd33333333);
    drain();
  endtask

  task automatic test_config_extremes();
    write_reg(REG_MAX_ENTRIES, 40'd3);
    write_reg(REG_WINDOW_SPAN, 40'd0);                    // evict down to two
    repeat (5) frame_at($urandom, 64'($urandom_range(1, 1000)));
    drain();
    write_reg(REG_MAX_ENTRIES, 40'd0);                    // clamped low
    write_reg(REG_WINDOW_SPAN, 40'hFF_FFFF_FFFF);
    repeat (6) frame_at($urandom, 64'($urandom_range(0, 3)));
    drain();
    write_reg(REG_MAX_ENTRIES, 40'd127);                  // clamped high
    repeat (70) frame_at($urandom_range(0, 200000), 64'($urandom_range(1, 50000)));
    drain();
    write_reg(REG_MAX_ENTRIES, 40'd5);                    // shrink below occupancy
    repeat (8) frame_at($urandom, 64'($urandom_range(1, 50000)));
    drain();
  endtask

  task automatic test_random(int n, bit gaps);
    logic [63:0] st;
    logic [31:0] b;
    stall_en = gaps;
    for (int i = 0; i < n; i++) begin
      if (i % 100 == 0) begin
        drain();
        write_reg(REG_MAX_ENTRIES, 40'($urandom_range(0, 127)));
        write_reg(REG_WINDOW_SPAN, 40'({8'($urandom_range(0, 255)), $urandom} >>
                  $urandom_range(0, 39)));
      end
      case ($urandom_range(0, 19))
        0: send_item(FUNC_CLEAR, $urandom, 48'({$urandom, $urandom}));
        1: send_item(FUNC_FRAME, $urandom, 48'({$urandom, $urandom}));
        default: begin
          st = $urandom_range(0, 3) == 0 ? 64'({$urandom, $urandom}) & 64'hFFFF_FFFF_FF
                                          : 64'($urandom_range(0, 100000000));
          b = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 100000);
          frame_at(b, st);
        end
      endcase
    end
    drain();
  endtask

  initial begin
    errors = 0; cycles = 0; stall_en = 1'b1; stall_left = 0; now_ts = 0;
    exp_wr = 0; exp_rd = 0;
    m_oldest = 0; m_count = 0; m_bytes = 0; m_total = 0;
    m_cap_reg = 50; m_span_lim = 64'd5000000000;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_extremes();
    test_random(300, 1'b1);
    test_random(100, 1'b0);
    repeat (300) @(posedge clk_i);
    if (errors == 0 && pending_cnt() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
